FILE: rtl/sdtq_pkg.sv
// sdtq_pkg: shared types and constants for the sorted deadline timer queue
// used by sdtq_cell and sorted_deadline_timer_queue_top; depends on nothing
`timescale 1ns / 1ps

package sdtq_pkg;

   localparam int OPCODE_W = 2;
   localparam int HANDLE_W = 8;
   localparam int PAYLOAD_W = 32;
   localparam int FIELD_TIME_W = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 5;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // broadcast from the control logic to every cell
   typedef struct packed {
      logic insert_en;
      logic delete_en;
      logic pop_en;
   } cell_ctrl_type;

endpackage

FILE: rtl/sdtq_cell.sv
// sdtq_cell: one slot of the sorted timer row, trades entries with its neighbors
// depends on sdtq_pkg
`timescale 1ns / 1ps

module sdtq_cell #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sdtq_pkg::cell_ctrl_type          ctrl,
   input  logic [TIME_WIDTH-1:0]            new_deadline,
   input  logic [sdtq_pkg::HANDLE_W-1:0]    new_handle,
   input  logic [sdtq_pkg::PAYLOAD_W-1:0]   new_payload,
   input  logic                             left_valid,
   input  logic [TIME_WIDTH-1:0]            left_deadline,
   input  logic [sdtq_pkg::HANDLE_W-1:0]    left_handle,
   input  logic [sdtq_pkg::PAYLOAD_W-1:0]   left_payload,
   input  logic                             right_valid,
   input  logic [TIME_WIDTH-1:0]            right_deadline,
   input  logic [sdtq_pkg::HANDLE_W-1:0]    right_handle,
   input  logic [sdtq_pkg::PAYLOAD_W-1:0]   right_payload,
   input  logic                             lt_in,
   output logic                             lt_out,
   input  logic                             hit_in,
   output logic                             hit_out,
   output logic                             valid,
   output logic [TIME_WIDTH-1:0]            deadline,
   output logic [sdtq_pkg::HANDLE_W-1:0]    handle,
   output logic [sdtq_pkg::PAYLOAD_W-1:0]   payload
);
   import sdtq_pkg::*;

   logic                  valid_ff, valid_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [PAYLOAD_W-1:0]  payload_ff, payload_in;
   logic                  lt;
   logic                  match;

   assign lt = valid_ff && (deadline_ff < new_deadline);
   assign match = valid_ff && (handle_ff == new_handle);
   assign lt_out = lt;
   assign hit_out = hit_in | match;

   always_comb begin
      priority if (ctrl.pop_en || (ctrl.delete_en && (hit_in || match))) begin
         // close the gap: pull the entry from the right
         valid_in = right_valid;
         deadline_in = right_deadline;
         handle_in = right_handle;
         payload_in = right_payload;
      end else if (ctrl.insert_en && !lt && lt_in) begin
         valid_in = 1'b1;
         deadline_in = new_deadline;
         handle_in = new_handle;
         payload_in = new_payload;
      end else if (ctrl.insert_en && !lt) begin
         // make room: take the entry from the left
         valid_in = left_valid;
         deadline_in = left_deadline;
         handle_in = left_handle;
         payload_in = left_payload;
      end else begin
         valid_in = valid_ff;
         deadline_in = deadline_ff;
         handle_in = handle_ff;
         payload_in = payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      handle_ff <= handle_in;
      payload_ff <= payload_in;
   end

   assign valid = valid_ff;
   assign deadline = deadline_ff;
   assign handle = handle_ff;
   assign payload = payload_ff;

endmodule

FILE: rtl/sorted_deadline_timer_queue_top.sv
// sorted_deadline_timer_queue_top: row of timer cells, tick counter and response register
// depends on sdtq_pkg and sdtq_cell
`timescale 1ns / 1ps

// Usage
//   req_* channel carries one request: insert (handle, deadline, payload),
//   delete by handle, or clock tick. rsp_* channel returns exactly one
//   response per request: status, fired flag with the fired timer's handle
//   and payload, the tick count and the number of pending timers after it.
//   Timers are held in deadline order in a row of QUEUE_DEPTH cells; every
//   cell compares itself with the request at once and moves its entry one
//   step left or right. The response is registered and valid in the
//   cycle after the request is taken. Throughput: one request per cycle
//   while rsp_ready is high, set by the cell row update and the
//   one-entry response register.
//   Stall: while a response waits and rsp_ready is low, req_ready is low;
//   req_ready follows rsp_ready in the same cycle so no bubble is added.
//   Reset: all cells empty, tick count zero, no response pending.
//   No clearing pass is needed after reset.
module sorted_deadline_timer_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sdtq_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [sdtq_pkg::HANDLE_W-1:0]       req_timer_handle,
   input  logic [sdtq_pkg::FIELD_TIME_W-1:0]   req_deadline,
   input  logic [sdtq_pkg::PAYLOAD_W-1:0]      req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sdtq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_fired,
   output logic [sdtq_pkg::HANDLE_W-1:0]       rsp_fired_handle,
   output logic [sdtq_pkg::PAYLOAD_W-1:0]      rsp_fired_payload,
   output logic [sdtq_pkg::FIELD_TIME_W-1:0]   rsp_tick_count,
   output logic [sdtq_pkg::OCC_W-1:0]          rsp_occupancy
);
   import sdtq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                  accept;
   cell_ctrl_type         ctrl;
   logic [TIME_WIDTH-1:0] new_deadline;

   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [TIME_WIDTH-1:0]  c_deadline [QUEUE_DEPTH];
   logic [HANDLE_W-1:0]    c_handle [QUEUE_DEPTH];
   logic [PAYLOAD_W-1:0]   c_payload [QUEUE_DEPTH];
   logic                   lt_chain [QUEUE_DEPTH+1];
   logic                   hit_chain [QUEUE_DEPTH+1];

   logic [TIME_WIDTH-1:0]  ticks_ff, ticks_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   full;
   logic                   found;
   logic                   fire;
   logic                   is_insert, is_delete, is_tick;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   fired_ff, fired_in;
   logic [HANDLE_W-1:0]    fired_handle_ff, fired_handle_in;
   logic [PAYLOAD_W-1:0]   fired_payload_ff, fired_payload_in;
   logic [FIELD_TIME_W-1:0] tick_count_ff, tick_count_in;
   logic [OCC_W-1:0]       occupancy_ff, occupancy_in;

   // request fields into internal widths, internal tick count and occupancy into response widths
   generate
      if (TIME_WIDTH > FIELD_TIME_W) begin : g_dl_wide
         assign new_deadline = {{(TIME_WIDTH-FIELD_TIME_W){1'b0}}, req_deadline};
         assign tick_count_in = ticks_in[FIELD_TIME_W-1:0];
      end else if (TIME_WIDTH == FIELD_TIME_W) begin : g_dl_same
         assign new_deadline = req_deadline;
         assign tick_count_in = ticks_in;
      end else begin : g_dl_narrow
         assign new_deadline = req_deadline[TIME_WIDTH-1:0];
         assign tick_count_in = {{(FIELD_TIME_W-TIME_WIDTH){1'b0}}, ticks_in};
      end
      if (CNT_W > OCC_W) begin : g_occ_wide
         assign occupancy_in = count_in[OCC_W-1:0];
      end else if (CNT_W == OCC_W) begin : g_occ_same
         assign occupancy_in = count_in;
      end else begin : g_occ_narrow
         assign occupancy_in = {{(OCC_W-CNT_W){1'b0}}, count_in};
      end
   endgenerate

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign is_insert = (req_opcode == OP_INSERT);
   assign is_delete = (req_opcode == OP_DELETE);
   assign is_tick = (req_opcode == OP_TICK);

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign found = hit_chain[QUEUE_DEPTH];
   assign ticks_in = (accept && is_tick) ? ticks_ff + TIME_WIDTH'(1) : ticks_ff;
   // head expires against the advanced count
   assign fire = valid_vec[0] && (c_deadline[0] <= ticks_in);

   assign ctrl.insert_en = accept && is_insert && !full;
   assign ctrl.delete_en = accept && is_delete;
   assign ctrl.pop_en = accept && is_tick && fire;

   assign lt_chain[0] = 1'b1;
   assign hit_chain[0] = 1'b0;

   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic                  l_valid, r_valid;
         logic [TIME_WIDTH-1:0] l_deadline, r_deadline;
         logic [HANDLE_W-1:0]   l_handle, r_handle;
         logic [PAYLOAD_W-1:0]  l_payload, r_payload;

         if (i == 0) begin : g_left_edge
            assign l_valid = 1'b0;
            assign l_deadline = '0;
            assign l_handle = '0;
            assign l_payload = '0;
         end else begin : g_left
            assign l_valid = valid_vec[i-1];
            assign l_deadline = c_deadline[i-1];
            assign l_handle = c_handle[i-1];
            assign l_payload = c_payload[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_right_edge
            assign r_valid = 1'b0;
            assign r_deadline = '0;
            assign r_handle = '0;
            assign r_payload = '0;
         end else begin : g_right
            assign r_valid = valid_vec[i+1];
            assign r_deadline = c_deadline[i+1];
            assign r_handle = c_handle[i+1];
            assign r_payload = c_payload[i+1];
         end

         sdtq_cell #(
            .TIME_WIDTH(TIME_WIDTH)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (ctrl),
            .new_deadline  (new_deadline),
            .new_handle    (req_timer_handle),
            .new_payload   (req_payload),
            .left_valid    (l_valid),
            .left_deadline (l_deadline),
            .left_handle   (l_handle),
            .left_payload  (l_payload),
            .right_valid   (r_valid),
            .right_deadline(r_deadline),
            .right_handle  (r_handle),
            .right_payload (r_payload),
            .lt_in         (lt_chain[i]),
            .lt_out        (lt_chain[i+1]),
            .hit_in        (hit_chain[i]),
            .hit_out       (hit_chain[i+1]),
            .valid         (valid_vec[i]),
            .deadline      (c_deadline[i]),
            .handle        (c_handle[i]),
            .payload       (c_payload[i])
         );
      end
   endgenerate

   always_comb begin
      priority if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop_en || (ctrl.delete_en && found)) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      status_in = ST_OK;
      if (is_insert && full) begin
         status_in = ST_FULL;
      end else if (is_delete && !found) begin
         status_in = ST_NOT_FOUND;
      end
      fired_in = is_tick && fire;
      fired_handle_in = fired_in ? c_handle[0] : '0;
      fired_payload_in = fired_in ? c_payload[0] : '0;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ticks_ff <= ticks_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         fired_ff <= fired_in;
         fired_handle_ff <= fired_handle_in;
         fired_payload_ff <= fired_payload_in;
         tick_count_ff <= tick_count_in;
         occupancy_ff <= occupancy_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_fired = fired_ff;
   assign rsp_fired_handle = fired_handle_ff;
   assign rsp_fired_payload = fired_payload_ff;
   assign rsp_tick_count = tick_count_ff;
   assign rsp_occupancy = occupancy_ff;

   // occupied cells always match the counter
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("cell valid bits disagree with the occupancy counter");

   // the last cell earlier than the request implies a full row
   a_lt_all_means_full: assert property (@(posedge clock) disable iff (reset)
      lt_chain[QUEUE_DEPTH] |-> full)
      else $error("compare chain ran past an empty cell");

   // a tick request advances the counter by exactly one
   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      accept && is_tick |=> ticks_ff == $past(ticks_ff) + TIME_WIDTH'(1))
      else $error("tick did not advance the counter");

   // no handle or payload leaks out when nothing fired
   a_quiet_when_not_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !fired_ff |-> fired_handle_ff == '0 && fired_payload_ff == '0)
      else $error("fired fields nonzero without a fired timer");

endmodule
